// File: design/lrupr_pkg.sv
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

// File: design/lru_page_replacement_unit.sv
// LRU page frame table, fully associative over up to MAX_FRAMES frames.
// A reference word is presented on i_page_number with i_start and is taken
// at a clock edge where i_start is high and o_busy is low. The block then
// walks the page store one frame per cycle through its single read port,
// stopping at the first frame that holds the page or after the last active
// frame. A hit ends the scan at the frame that holds the page; a fault
// ends it after the last active frame. The result word is registered when
// the scan ends. The next word can be taken in the cycle the result is
// shown, so a word is not taken while the last one is still in flight.
// Each result word is on the o_ result ports for exactly one cycle, marked
// by o_valid. The receiver cannot stall; it must take the word in that
// cycle. The running totals on o_hit_total and o_fault_total saturate.
// frames_in_use is written through i_cfg_wr_en and i_cfg_wr_data; the user
// must write it only while the block is idle, which the block does not
// enforce. Zero acts as one and values above MAX_FRAMES act as MAX_FRAMES.
// Reset empties every frame, clears both totals and sets frames_in_use to 16.
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0] i_cfg_wr_data,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [IDX_W-1:0]            o_frame_index,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [lrupr_pkg::CNT_W-1:0] o_hit_total,
    output logic [lrupr_pkg::CNT_W-1:0] o_fault_total
);

    localparam int N_W = $clog2(MAX_FRAMES + 1);

    lrupr_pkg::t_state r_state;
    lrupr_pkg::t_state n_state;

    logic [lrupr_pkg::CFG_W-1:0] r_cfg;
    logic [N_W-1:0]              s_active_n;
    logic [MAX_FRAMES-1:0]       s_active;

    logic [MAX_FRAMES-1:0]       r_frame_valid;
    logic [IDX_W-1:0]            r_rec [MAX_FRAMES];
    logic [PAGE_BITS-1:0]        r_page_mem [MAX_FRAMES];

    logic [PAGE_BITS-1:0]        r_rd_data;
    logic [PAGE_BITS-1:0]        r_page;
    logic [PAGE_BITS-1:0]        r_ev_page_hold;
    logic [IDX_W-1:0]            r_chk;
    logic                        r_empty_found;
    logic [IDX_W-1:0]            r_empty_idx;
    logic [IDX_W-1:0]            r_victim_idx;

    logic                        s_empty_found;
    logic [IDX_W-1:0]            s_empty_idx;
    logic [MAX_FRAMES-1:0]       s_oldest;
    logic                        s_victim_found;
    logic [IDX_W-1:0]            s_victim_idx;

    logic                        s_accept;
    logic                        s_hit_now;
    logic                        s_last;
    logic                        s_finish;
    logic [IDX_W-1:0]            s_rd_addr;
    logic                        s_evict;
    logic                        s_was_valid;
    logic [IDX_W-1:0]            s_frame;
    logic [IDX_W-1:0]            s_age;
    logic [PAGE_BITS-1:0]        s_ev_page;

    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [IDX_W-1:0]            r_out_frame;
    logic                        r_out_ev_valid;
    logic [PAGE_BITS-1:0]        r_out_ev_page;
    logic [lrupr_pkg::CNT_W-1:0] r_hits;
    logic [lrupr_pkg::CNT_W-1:0] r_faults;

    always_comb begin
        if (r_cfg == '0) begin
            s_active_n = N_W'(1);
        end else if (32'(r_cfg) > 32'(MAX_FRAMES)) begin
            s_active_n = N_W'(MAX_FRAMES);
        end else begin
            s_active_n = N_W'(r_cfg);
        end
        for (int j = 0; j < MAX_FRAMES; j++) begin
            s_active[j] = (N_W'(j) < s_active_n);
        end
    end

    // The empty frame and the replacement victim depend only on the active frame count,
    // the frame valid flags and the frame ages, which stay still while a word is being looked up.
    always_comb begin
        s_empty_found  = 1'b0;
        s_empty_idx    = '0;
        s_victim_found = 1'b0;
        s_victim_idx   = '0;
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (!s_empty_found && s_active[j] && !r_frame_valid[j]) begin
                s_empty_found = 1'b1;
                s_empty_idx   = IDX_W'(j);
            end
        end
        for (int j = 0; j < MAX_FRAMES; j++) begin
            s_oldest[j] = s_active[j];
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (s_active[i] && (r_rec[i] > r_rec[j])) begin
                    s_oldest[j] = 1'b0;
                end
            end
        end
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (!s_victim_found && s_oldest[j]) begin
                s_victim_found = 1'b1;
                s_victim_idx   = IDX_W'(j);
            end
        end
    end

    assign s_accept = i_start && (r_state == lrupr_pkg::ST_IDLE);

    always_comb begin
        n_state   = r_state;
        s_rd_addr = '0;
        s_finish  = 1'b0;
        s_hit_now = r_frame_valid[r_chk] && (r_rd_data == r_page);
        s_last    = ((N_W'(r_chk) + N_W'(1)) == s_active_n);
        case (r_state)
            lrupr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN: begin
                if (s_hit_now || s_last) begin
                    s_finish = 1'b1;
                    n_state  = lrupr_pkg::ST_IDLE;
                end else begin
                    s_rd_addr = r_chk + IDX_W'(1);
                end
            end
            default: begin
                n_state = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_evict     = !s_hit_now && !r_empty_found;
        s_was_valid = s_hit_now || !r_empty_found;
        if (s_hit_now) begin
            s_frame = r_chk;
        end else if (r_empty_found) begin
            s_frame = r_empty_idx;
        end else begin
            s_frame = r_victim_idx;
        end
        s_age     = r_rec[s_frame];
        s_ev_page = (r_chk == r_victim_idx) ? r_rd_data : r_ev_page_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_page_mem[s_rd_addr];
        if (s_finish && !s_hit_now) begin
            r_page_mem[s_frame] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_page        <= i_page_number;
            r_chk         <= '0;
            r_empty_found <= s_empty_found;
            r_empty_idx   <= s_empty_idx;
            r_victim_idx  <= s_victim_idx;
        end else if (r_state == lrupr_pkg::ST_SCAN) begin
            r_chk <= s_rd_addr;
            if (r_chk == r_victim_idx) begin
                r_ev_page_hold <= r_rd_data;
            end
        end
        if (s_finish) begin
            r_out_hit      <= s_hit_now;
            r_out_frame    <= s_frame;
            r_out_ev_valid <= s_evict;
            r_out_ev_page  <= s_evict ? s_ev_page : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= lrupr_pkg::CFG_RESET;
            r_out_valid   <= 1'b0;
            r_hits        <= '0;
            r_faults      <= '0;
            r_frame_valid <= '0;
            for (int j = 0; j < MAX_FRAMES; j++) begin
                r_rec[j] <= '0;
            end
        end else begin
            r_out_valid <= s_finish;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (s_finish) begin
                if (s_hit_now) begin
                    if (r_hits != lrupr_pkg::CNT_MAX) begin
                        r_hits <= r_hits + lrupr_pkg::CNT_W'(1);
                    end
                end else if (r_faults != lrupr_pkg::CNT_MAX) begin
                    r_faults <= r_faults + lrupr_pkg::CNT_W'(1);
                end
                r_frame_valid[s_frame] <= 1'b1;
                // The touched frame becomes the youngest; valid frames that
                // were younger than it, or all of them on a fill, age by one.
                for (int j = 0; j < MAX_FRAMES; j++) begin
                    if (IDX_W'(j) == s_frame) begin
                        r_rec[j] <= '0;
                    end else if (r_frame_valid[j] && (!s_was_valid || (r_rec[j] < s_age))) begin
                        r_rec[j] <= r_rec[j] + IDX_W'(1);
                    end
                end
            end
        end
    end

    assign o_busy          = (r_state != lrupr_pkg::ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_frame;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_total     = r_hits;
    assign o_fault_total   = r_faults;

endmodule

// File: design/lrupr_checker.sv
module lrupr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic                        o_hit,
    input logic [lrupr_pkg::CNT_W-1:0] o_hit_total,
    input logic [lrupr_pkg::CNT_W-1:0] o_fault_total
);

    // A result word only follows a lookup that was in progress.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result word without a lookup in progress");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("lookup started without a start");

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |->
            (o_fault_total == $past(o_fault_total) + lrupr_pkg::CNT_W'(1)) ||
            (o_fault_total == lrupr_pkg::CNT_MAX))
        else $error("fault total did not advance on a fault");

    a_hit_count_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> $stable(o_hit_total))
        else $error("hit total moved on a fault");

    a_totals_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !o_valid |-> $stable(o_hit_total) && $stable(o_fault_total))
        else $error("totals moved without a result word");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (.*);

// File: sim/tb.sv
module tb;

    localparam int NUM_FRAMES  = lrupr_pkg::MAX_FRAMES_DEF;
    localparam int PAGE_W      = lrupr_pkg::PAGE_BITS_DEF;
    localparam int IDX_W       = $clog2(NUM_FRAMES);
    localparam int CFG_W       = lrupr_pkg::CFG_W;
    localparam int CNT_W       = lrupr_pkg::CNT_W;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
    } t_lookup;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_start       = 1'b0;
    logic [PAGE_W-1:0] i_page_number = '0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              o_busy;
    logic              o_valid;
    logic              o_hit;
    logic [IDX_W-1:0]  o_frame_index;
    logic              o_evicted_valid;
    logic [PAGE_W-1:0] o_evicted_page;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_fault_total;

    logic [PAGE_W-1:0] page_in_frame [NUM_FRAMES];
    bit                frame_holds [NUM_FRAMES];
    int                frame_rank [NUM_FRAMES];
    logic [CNT_W-1:0]  hits_so_far;
    logic [CNT_W-1:0]  faults_so_far;
    logic [CFG_W-1:0]  frame_limit;

    t_lookup expected_lookups[$];
    int      err_count    = 0;
    int      stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    lru_page_replacement_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_page_number   (i_page_number),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_busy          (o_busy),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_fault_total   (o_fault_total)
    );

    function automatic void clear_table();
        for (int j = 0; j < NUM_FRAMES; j++) begin
            frame_holds[j]   = 1'b0;
            frame_rank[j]    = 0;
            page_in_frame[j] = '0;
        end
        hits_so_far   = '0;
        faults_so_far = '0;
        frame_limit   = lrupr_pkg::CFG_RESET;
    endfunction

    function automatic int active_frames();
        if (frame_limit == 0)
            return 1;
        if (frame_limit > NUM_FRAMES)
            return NUM_FRAMES;
        return int'(frame_limit);
    endfunction

    // Frames younger than f age by one; a frame that was empty ages all others.
    function automatic void make_newest(int f, bit was_held);
        int old_rank;
        old_rank = frame_rank[f];
        for (int j = 0; j < NUM_FRAMES; j++) begin
            if (j != f && frame_holds[j] && (!was_held || frame_rank[j] < old_rank))
                frame_rank[j]++;
        end
        frame_rank[f] = 0;
    endfunction

    function automatic t_lookup predict_lookup(logic [PAGE_W-1:0] page);
        t_lookup r;
        int      n;
        int      f;
        bit      hit_now;
        bit      empty_found;
        r           = '0;
        n           = active_frames();
        f           = 0;
        hit_now     = 1'b0;
        empty_found = 1'b0;
        for (int j = 0; j < n && !hit_now; j++) begin
            if (frame_holds[j] && page_in_frame[j] == page) begin
                hit_now = 1'b1;
                f       = j;
            end
        end
        if (hit_now) begin
            make_newest(f, 1'b1);
            if (hits_so_far != lrupr_pkg::CNT_MAX)
                hits_so_far++;
        end else begin
            for (int j = 0; j < n && !empty_found; j++) begin
                if (!frame_holds[j]) begin
                    empty_found = 1'b1;
                    f           = j;
                end
            end
            if (empty_found) begin
                make_newest(f, 1'b0);
                frame_holds[f] = 1'b1;
            end else begin
                f = 0;
                for (int j = 1; j < n; j++) begin
                    if (frame_rank[j] > frame_rank[f])
                        f = j;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = page_in_frame[f];
                make_newest(f, 1'b1);
            end
            page_in_frame[f] = page;
            if (faults_so_far != lrupr_pkg::CNT_MAX)
                faults_so_far++;
        end
        r.hit         = hit_now;
        r.frame_index = IDX_W'(f);
        r.hit_total   = hits_so_far;
        r.fault_total = faults_so_far;
        return r;
    endfunction

    function automatic void note_failure(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : check_words
        t_lookup seen;
        t_lookup want;
        if (!i_rst_n) begin
            clear_table();
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (i_cfg_wr_en)
                frame_limit = i_cfg_wr_data;
            if (o_valid) begin
                stall_cycles = 0;
                seen = {o_hit, o_frame_index, o_evicted_valid, o_evicted_page,
                        o_hit_total, o_fault_total};
                if (expected_lookups.size() == 0) begin
                    note_failure("Result word arrived with none outstanding.");
                end else begin
                    want = expected_lookups.pop_front();
                    if (seen.hit != want.hit || seen.frame_index != want.frame_index
                        || seen.evicted_valid != want.evicted_valid
                        || seen.evicted_page != want.evicted_page
                        || seen.hit_total != want.hit_total
                        || seen.fault_total != want.fault_total)
                        note_failure($sformatf({"Mismatch: expected hit=%0d frame=%0d ",
                            "evicted=%0d/%h hits=%0d faults=%0d, got hit=%0d frame=%0d ",
                            "evicted=%0d/%h hits=%0d faults=%0d"},
                            want.hit, want.frame_index, want.evicted_valid,
                            want.evicted_page, want.hit_total, want.fault_total,
                            seen.hit, seen.frame_index, seen.evicted_valid,
                            seen.evicted_page, seen.hit_total, seen.fault_total));
                end
            end
            if (i_start && !o_busy) begin
                stall_cycles = 0;
                expected_lookups.push_back(predict_lookup(i_page_number));
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [PAGE_W-1:0] page);
        i_start       <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_cycle();
        i_start       <= 1'b0;
        i_page_number <= PAGE_W'($urandom);
        @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_lookups.size() != 0);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] count);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_fill_and_hit();
        set_frames(CFG_W'(NUM_FRAMES));
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'hFFFF);
    endtask

    task automatic test_lru_eviction();
        set_frames(CFG_W'(3));
        send_word(16'h1234);
        send_word(16'h5555);
        send_word(16'hAAAA);
        send_word(16'h1234);
    endtask

    // Drives zero, all-ones and over-range frame counts, then shrinks and regrows
    // the count; a page placed while the count was small must still hit afterwards.
    task automatic test_frame_count_limits();
        set_frames('0);
        send_word(16'h1234);
        send_word(16'h1234);
        set_frames('1);
        send_word(16'h1234);
        send_word(16'h8001);
        set_frames(CFG_W'(NUM_FRAMES + 1));
        send_word(16'h7FFE);
        set_frames(CFG_W'(2));
        send_word(16'h0F0F);
        send_word(16'hA5A5);
        set_frames(CFG_W'(NUM_FRAMES));
        send_word(16'h0F0F);
        send_word(16'h5A5A);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int word_total);
        int                sent;
        int                spread;
        int                gap;
        bit                quiet;
        logic [PAGE_W-1:0] base;
        logic [CFG_W-1:0]  count;
        sent = 0;
        while (sent < word_total) begin
            case ($urandom_range(0, 9))
                0: count = '0;
                1: count = CFG_W'(NUM_FRAMES);
                2: count = CFG_W'($urandom_range(NUM_FRAMES + 1, 31));
                3: count = CFG_W'(1);
                default: count = CFG_W'($urandom_range(1, NUM_FRAMES));
            endcase
            set_frames(count);
            base   = PAGE_W'($urandom);
            spread = (count == 0) ? 1 : (count > NUM_FRAMES) ? NUM_FRAMES : int'(count);
            spread = spread + $urandom_range(0, 4);
            quiet  = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(PAGE_W'($urandom));
                else
                    send_word(base ^ PAGE_W'($urandom_range(0, spread)));
                sent++;
                if ($urandom_range(0, 39) == 0)
                    wait_for_results();
                gap = 0;
                while (!quiet && gap < 20 && $urandom_range(0, 99) < idle_pct) begin
                    idle_cycle();
                    gap++;
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_and_hit();
        test_lru_eviction();
        test_frame_count_limits();
        test_random_traffic(19, 233);
        test_random_traffic(58, 233);
        test_random_traffic(0, 234);
        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (expected_lookups.size() != 0)
            note_failure($sformatf("%0d result words never arrived.",
                                   expected_lookups.size()));
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
design/lrupr_pkg.sv
design/lru_page_replacement_unit.sv
design/lrupr_checker.sv
sim/tb.sv
